// File: design/assert_macros.svh
// assertion macros for the checker file
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock while out of reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/ahpc_pkg.sv
// shared types and constants for the axis homing pid controller
// no dependencies
`timescale 1ns / 1ps

package ahpc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KP    = 3'd0,
    CFG_KI    = 3'd1,
    CFG_KD    = 3'd2,
    CFG_DEAD  = 3'd3,
    CFG_FAST  = 3'd4,
    CFG_SLOW  = 3'd5,
    CFG_BRAKE = 3'd6
  } cfg_idx_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_HOME = 1'b1;

  // homing phases
  localparam logic [2:0] PH_CONTROL   = 3'd0;
  localparam logic [2:0] PH_SEEK_LOW  = 3'd1;
  localparam logic [2:0] PH_BACK_OFF  = 3'd2;
  localparam logic [2:0] PH_SLOW_LOW  = 3'd3;
  localparam logic [2:0] PH_SEEK_HIGH = 3'd4;
  localparam logic [2:0] PH_BACK_HIGH = 3'd5;
  localparam logic [2:0] PH_SLOW_HIGH = 3'd6;

  localparam int DIV_STEPS     = 48;
  localparam int ERROR_DIVISOR = 1000;
  localparam int VEL_LIMIT     = 1000;

endpackage

// File: design/axis_homing_pid_controller.sv
// axis controller top level: encoder unwrap, span scaling, homing sequencer, pid step
// depends on ahpc_pkg
`timescale 1ns / 1ps

// One item at a time: in_ready is high only while the sequencer is idle. A start-homing
// item gives no result. A control tick during homing uses the shared 48-step restoring
// divider for the span scaling. A tick in normal control also runs the divider once for
// the derivative by elapsed time, unless elapsed time is zero. The error is divided by
// 1000 with a reciprocal multiply, and the single shared 33x17 multiplier handles the
// scale, integral and gain products. With a zero span the scaling division is skipped. A
// finished result sits in the output register, so the next item is accepted while it
// waits. Configuration writes are taken at any time (cfg_ready is always high) and must
// only be issued while the block is idle.
module axis_homing_pid_controller #(
  parameter int TURN_MILLIDEG = 360000,
  parameter int POS_SCALE     = 1000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic               in_low_limit_hit,
  input  logic               in_high_limit_hit,
  input  logic [18:0]        in_encoder_angle,
  input  logic [15:0]        in_elapsed_ms,
  input  logic [19:0]        in_target_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_drive_active,
  output logic signed [10:0] out_velocity,
  output logic [9:0]         out_brake_out,
  output logic [9:0]         out_scaled_position,
  output logic [2:0]         out_homing_phase_out,
  output logic               out_calibrated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_UNWRAP, S_SC_MUL, S_SC_DIV, S_DIV, S_SC_FIX, S_PHASE,
    S_ERR_DIV, S_ERR_FIX, S_DRV_DIV, S_DRV_FIX, S_INT_MUL, S_INT_UPD,
    S_P_ACC, S_I_ACC, S_D_ACC, S_PID_VEL, S_FINISH
  } state_t;

  localparam logic signed [21:0] TURN_D  = 22'(TURN_MILLIDEG);
  localparam logic signed [21:0] HALF_D  = 22'(TURN_MILLIDEG / 2);
  localparam logic signed [33:0] TURN_W  = 34'(TURN_MILLIDEG);
  localparam logic signed [16:0] SCALE_B = 17'(POS_SCALE);
  localparam logic [47:0]        SCALE_Q = 48'(POS_SCALE);
  localparam logic [15:0]        SCALE_S = 16'(POS_SCALE);
  localparam logic signed [49:0] I_MAX   = 50'sd2147483647;
  localparam logic signed [49:0] I_MIN   = -50'sd2147483648;
  localparam logic signed [51:0] ROUND_A = 52'sd255;
  localparam logic signed [51:0] V_MAX_A = 52'(ahpc_pkg::VEL_LIMIT);
  localparam logic signed [51:0] V_MIN_A = -52'(ahpc_pkg::VEL_LIMIT);
  localparam logic signed [11:0] V_MAX   = 12'(ahpc_pkg::VEL_LIMIT);
  localparam logic signed [11:0] V_MIN   = -12'(ahpc_pkg::VEL_LIMIT);
  localparam logic [9:0]         B_MAX   = 10'(ahpc_pkg::VEL_LIMIT);
  localparam logic [5:0]         DIV_LAST = 6'(ahpc_pkg::DIV_STEPS - 1);
  // ceil(2^30 / 1000), exact floor division for magnitudes below 2^21
  localparam logic [20:0]        ERR_RECIP = 21'((64'sd1073741824
                                   + 64'(ahpc_pkg::ERROR_DIVISOR) - 64'sd1)
                                   / 64'(ahpc_pkg::ERROR_DIVISOR));

  state_t state_r;
  state_t ret_r;

  // configuration
  logic [15:0] kp_r, ki_r, kd_r;
  logic [14:0] dead_r;
  logic [9:0]  fast_r, slow_r, brake_r;

  // architectural state
  logic [2:0]         phase_r;
  logic [31:0]        pos_r;
  logic [18:0]        prev_angle_r;
  logic [31:0]        span_r;
  logic signed [15:0] prev_err_r;
  logic signed [31:0] integ_r;
  logic               cal_r;

  // latched item
  logic        lo_r, hi_r;
  logic [18:0] angle_r;
  logic [15:0] dt_r;
  logic [19:0] target_r;

  // working registers
  logic signed [49:0] prod_r;
  logic signed [51:0] acc_r;
  logic [15:0]        scaled_r;
  logic signed [15:0] err_r;
  logic signed [16:0] deriv_r;
  logic signed [11:0] vel_r;

  // divider
  logic [31:0] rem_r;
  logic [47:0] quo_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        div_neg_r;

  // output register
  logic               out_valid_r;
  logic               drive_r;
  logic signed [10:0] vel_out_r;
  logic [9:0]         brake_out_r;
  logic [9:0]         scaled_out_r;
  logic [2:0]         phase_out_r;
  logic               cal_out_r;

  // combinational helpers
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic [32:0]        div_shift;
  logic [32:0]        div_sub;
  logic               div_ge;
  logic signed [21:0] delta_raw, delta;
  logic [31:0]        pos_upd;
  logic signed [49:0] prod_abs;
  logic signed [31:0] span_abs;
  logic signed [21:0] diff, diff_abs;
  logic [47:0]        err_prod;
  logic signed [16:0] num, num_abs;
  logic signed [15:0] err_abs;
  logic signed [49:0] isum;
  logic signed [51:0] acc_adj, acc_q;
  logic signed [33:0] pos_w, span_w;
  logic signed [11:0] vel_sat, vel_fin;
  logic [9:0]         brake_sat;
  logic               load_out;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SC_MUL: begin
        mul_a = {pos_r[31], pos_r};
        mul_b = SCALE_B;
      end
      S_INT_MUL: begin
        mul_a = {{17{err_r[15]}}, err_r};
        mul_b = {1'b0, dt_r};
      end
      S_INT_UPD: begin
        mul_a = {{17{err_r[15]}}, err_r};
        mul_b = {kp_r[15], kp_r};
      end
      S_P_ACC: begin
        mul_a = {integ_r[31], integ_r};
        mul_b = {ki_r[15], ki_r};
      end
      S_I_ACC: begin
        mul_a = {{16{deriv_r[16]}}, deriv_r};
        mul_b = {kd_r[15], kd_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;

    // one restoring step per cycle
    div_shift = {rem_r, quo_r[47]};
    div_ge    = div_shift >= {1'b0, dvs_r};
    div_sub   = div_shift - {1'b0, dvs_r};

    // shortest way around the turn
    delta_raw = $signed({3'b000, angle_r}) - $signed({3'b000, prev_angle_r});
    if (delta_raw > HALF_D) begin
      delta = delta_raw - TURN_D;
    end else if (delta_raw < -HALF_D) begin
      delta = delta_raw + TURN_D;
    end else begin
      delta = delta_raw;
    end
    pos_upd = pos_r + {{10{delta[21]}}, delta};

    prod_abs = prod_r[49] ? -prod_r : prod_r;
    span_abs = span_r[31] ? -$signed(span_r) : $signed(span_r);
    diff     = $signed({2'b00, target_r}) - $signed({6'b000000, scaled_r});
    diff_abs = diff[21] ? -diff : diff;
    err_prod = 48'(diff_abs[20:0]) * 48'(ERR_RECIP);
    num      = {err_r[15], err_r} - {prev_err_r[15], prev_err_r};
    num_abs  = num[16] ? -num : num;
    err_abs  = err_r[15] ? -err_r : err_r;
    isum     = prod_r + {{18{integ_r[31]}}, integ_r};

    // truncate toward zero before the shift
    acc_adj = acc_r[51] ? acc_r + ROUND_A : acc_r;
    acc_q   = acc_adj >>> 8;

    pos_w  = {{2{pos_r[31]}}, pos_r};
    span_w = {{2{span_r[31]}}, span_r};

    if (vel_r > V_MAX) begin
      vel_sat = V_MAX;
    end else if (vel_r < V_MIN) begin
      vel_sat = V_MIN;
    end else begin
      vel_sat = vel_r;
    end
    if ((lo_r && vel_sat < 0) || (hi_r && vel_sat > 0)) begin
      vel_fin = '0;
    end else begin
      vel_fin = vel_sat;
    end
    brake_sat = (brake_r > B_MAX) ? B_MAX : brake_r;

    load_out = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      dead_r       <= '0;
      fast_r       <= '0;
      slow_r       <= '0;
      brake_r      <= '0;
      phase_r      <= ahpc_pkg::PH_CONTROL;
      pos_r        <= '0;
      prev_angle_r <= '0;
      span_r       <= '0;
      prev_err_r   <= '0;
      integ_r      <= '0;
      cal_r        <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ahpc_pkg::CFG_KP:    kp_r    <= cfg_data;
          ahpc_pkg::CFG_KI:    ki_r    <= cfg_data;
          ahpc_pkg::CFG_KD:    kd_r    <= cfg_data;
          ahpc_pkg::CFG_DEAD:  dead_r  <= cfg_data[14:0];
          ahpc_pkg::CFG_FAST:  fast_r  <= cfg_data[9:0];
          ahpc_pkg::CFG_SLOW:  slow_r  <= cfg_data[9:0];
          ahpc_pkg::CFG_BRAKE: brake_r <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_opcode == ahpc_pkg::OP_HOME) begin
              phase_r <= ahpc_pkg::PH_SEEK_LOW;
            end else begin
              lo_r     <= in_low_limit_hit;
              hi_r     <= in_high_limit_hit;
              angle_r  <= in_encoder_angle;
              dt_r     <= in_elapsed_ms;
              target_r <= in_target_position;
              state_r  <= S_UNWRAP;
            end
          end
        end
        S_UNWRAP: begin
          pos_r        <= pos_upd;
          prev_angle_r <= angle_r;
          state_r      <= S_SC_MUL;
        end
        S_SC_MUL: begin
          if (span_r == '0) begin
            scaled_r <= '0;
            state_r  <= S_PHASE;
          end else begin
            prod_r  <= mul_p;
            state_r <= S_SC_DIV;
          end
        end
        S_SC_DIV: begin
          quo_r     <= prod_abs[47:0];
          dvs_r     <= span_abs;
          rem_r     <= '0;
          cnt_r     <= '0;
          div_neg_r <= prod_r[49] ^ span_r[31];
          ret_r     <= S_SC_FIX;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r <= div_ge ? div_sub[31:0] : div_shift[31:0];
          quo_r <= {quo_r[46:0], div_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == DIV_LAST) begin
            state_r <= ret_r;
          end
        end
        S_SC_FIX: begin
          // a negative ratio saturates to zero
          if (div_neg_r) begin
            scaled_r <= '0;
          end else if (quo_r > SCALE_Q) begin
            scaled_r <= SCALE_S;
          end else begin
            scaled_r <= quo_r[15:0];
          end
          state_r <= S_PHASE;
        end
        S_PHASE: begin
          if (phase_r inside {[ahpc_pkg::PH_SEEK_LOW : ahpc_pkg::PH_SLOW_HIGH]}) begin
            state_r <= S_FINISH;
          end else begin
            state_r <= S_ERR_DIV;
          end
          case (phase_r)
            ahpc_pkg::PH_SEEK_LOW: begin
              if (lo_r) begin
                phase_r <= ahpc_pkg::PH_BACK_OFF;
                pos_r   <= '0;
                vel_r   <= '0;
              end else begin
                vel_r <= -$signed({2'b00, fast_r});
              end
            end
            ahpc_pkg::PH_BACK_OFF: begin
              if (pos_w >= TURN_W) begin
                phase_r <= ahpc_pkg::PH_SLOW_LOW;
                vel_r   <= '0;
              end else begin
                vel_r <= $signed({2'b00, fast_r});
              end
            end
            ahpc_pkg::PH_SLOW_LOW: begin
              if (lo_r) begin
                phase_r <= ahpc_pkg::PH_SEEK_HIGH;
                pos_r   <= '0;
                vel_r   <= '0;
              end else begin
                vel_r <= -$signed({2'b00, slow_r});
              end
            end
            ahpc_pkg::PH_SEEK_HIGH: begin
              if (hi_r) begin
                phase_r <= ahpc_pkg::PH_BACK_HIGH;
                span_r  <= pos_r;
                vel_r   <= '0;
              end else begin
                vel_r <= $signed({2'b00, fast_r});
              end
            end
            ahpc_pkg::PH_BACK_HIGH: begin
              if (pos_w <= span_w - TURN_W) begin
                phase_r <= ahpc_pkg::PH_SLOW_HIGH;
                vel_r   <= '0;
              end else begin
                vel_r <= -$signed({2'b00, fast_r});
              end
            end
            ahpc_pkg::PH_SLOW_HIGH: begin
              if (hi_r) begin
                phase_r <= ahpc_pkg::PH_CONTROL;
                cal_r   <= 1'b1;
                span_r  <= pos_r;
                vel_r   <= '0;
              end else begin
                vel_r <= $signed({2'b00, slow_r});
              end
            end
            default: begin
              // normal control, also the unused phase code
              phase_r <= ahpc_pkg::PH_CONTROL;
            end
          endcase
        end
        S_ERR_DIV: begin
          quo_r     <= err_prod;
          div_neg_r <= diff[21];
          state_r   <= S_ERR_FIX;
        end
        S_ERR_FIX: begin
          err_r <= div_neg_r ? -$signed(quo_r[45:30]) : $signed(quo_r[45:30]);
          if (dt_r == '0) begin
            deriv_r <= '0;
            state_r <= S_INT_MUL;
          end else begin
            state_r <= S_DRV_DIV;
          end
        end
        S_DRV_DIV: begin
          quo_r     <= {31'd0, num_abs};
          dvs_r     <= {16'd0, dt_r};
          rem_r     <= '0;
          cnt_r     <= '0;
          div_neg_r <= num[16];
          ret_r     <= S_DRV_FIX;
          state_r   <= S_DIV;
        end
        S_DRV_FIX: begin
          deriv_r <= div_neg_r ? -$signed(quo_r[16:0]) : $signed(quo_r[16:0]);
          state_r <= S_INT_MUL;
        end
        S_INT_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_INT_UPD;
        end
        S_INT_UPD: begin
          if (err_abs < $signed({1'b0, dead_r})) begin
            integ_r <= '0;
          end else if (isum > I_MAX) begin
            integ_r <= I_MAX[31:0];
          end else if (isum < I_MIN) begin
            integ_r <= I_MIN[31:0];
          end else begin
            integ_r <= isum[31:0];
          end
          prev_err_r <= err_r;
          prod_r     <= mul_p;
          state_r    <= S_P_ACC;
        end
        S_P_ACC: begin
          acc_r   <= {{2{prod_r[49]}}, prod_r};
          prod_r  <= mul_p;
          state_r <= S_I_ACC;
        end
        S_I_ACC: begin
          acc_r   <= acc_r + {{2{prod_r[49]}}, prod_r};
          prod_r  <= mul_p;
          state_r <= S_D_ACC;
        end
        S_D_ACC: begin
          acc_r   <= acc_r - {{2{prod_r[49]}}, prod_r};
          state_r <= S_PID_VEL;
        end
        S_PID_VEL: begin
          if (acc_q > V_MAX_A) begin
            vel_r <= V_MAX;
          end else if (acc_q < V_MIN_A) begin
            vel_r <= V_MIN;
          end else begin
            vel_r <= acc_q[11:0];
          end
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_out) begin
      drive_r      <= (vel_fin != 0);
      vel_out_r    <= vel_fin[10:0];
      brake_out_r  <= (vel_fin != 0) ? 10'd0 : brake_sat;
      scaled_out_r <= scaled_r[9:0];
      phase_out_r  <= phase_r;
      cal_out_r    <= cal_r;
    end
  end

  assign in_ready             = (state_r == S_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_drive_active     = drive_r;
  assign out_velocity         = vel_out_r;
  assign out_brake_out        = brake_out_r;
  assign out_scaled_position  = scaled_out_r;
  assign out_homing_phase_out = phase_out_r;
  assign out_calibrated       = cal_out_r;

endmodule

// File: design/ahpc_checker.sv
// port-level checker for the axis homing pid controller, bound to the top level
// depends on ahpc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ahpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_drive_active,
  input logic signed [10:0] out_velocity,
  input logic [9:0]         out_brake_out,
  input logic [2:0]         out_homing_phase_out
);

  localparam logic signed [10:0] VMAX = 11'(ahpc_pkg::VEL_LIMIT);

  // a result waiting for the sink stays up
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // drive flag follows a nonzero velocity
  `ASSERT_IMPLY(a_drive_vel, out_valid, out_drive_active == (out_velocity != 0))
  // no brake while driving
  `ASSERT_IMPLY(a_drive_brake, out_valid && out_drive_active, out_brake_out == 10'd0)
  // velocity within the saturation window
  `ASSERT_IMPLY(a_vel_range, out_valid, out_velocity <= VMAX && out_velocity >= -VMAX)
  // the unused phase code is never reported
  `ASSERT_IMPLY(a_phase_code, out_valid, out_homing_phase_out != 3'd7)

endmodule

bind axis_homing_pid_controller ahpc_checker u_ahpc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_drive_active     (out_drive_active),
  .out_velocity         (out_velocity),
  .out_brake_out        (out_brake_out),
  .out_homing_phase_out (out_homing_phase_out)
);

// File: sim/axis_homing_pid_controller_test.sv
// self-checking testbench for the axis homing pid controller: directed and guided random items
// keeps its own prediction of the controller state; depends on ahpc_pkg and the top level
`timescale 1ns / 1ps

module axis_homing_pid_controller_test;

  localparam longint TURN  = 360000;
  localparam longint SCALE = 1000;
  localparam longint VMAX  = 1000;

  typedef struct {
    logic               drive;
    logic signed [10:0] vel;
    logic [9:0]         brake;
    logic [9:0]         scaled;
    logic [2:0]         phase;
    logic               cal;
  } motion_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_opcode, in_low_limit_hit, in_high_limit_hit;
  logic [18:0] in_encoder_angle;
  logic [15:0] in_elapsed_ms;
  logic [19:0] in_target_position;
  logic out_valid, out_ready, out_drive_active, out_calibrated;
  logic signed [10:0] out_velocity;
  logic [9:0] out_brake_out, out_scaled_position;
  logic [2:0] out_homing_phase_out;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  axis_homing_pid_controller DUT (.*);

  // predicted controller state and registers
  logic signed [15:0] m_kp, m_ki, m_kd;
  logic [14:0] m_dead;
  logic [9:0] m_fast, m_slow, m_brake;
  logic [2:0] m_phase;
  logic [31:0] m_pos_ticks, m_span;
  logic [18:0] m_prev_angle;
  logic signed [31:0] m_prev_err, m_integral;
  logic m_cal;

  motion_t pending_motion[$];
  int errors;
  int send_idle_pct, stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic model_item(input logic op, input logic lo, input logic hi,
                            input logic [18:0] ang, input logic [15:0] dt,
                            input logic [19:0] tgt);
    longint delta, pos, span, scaled, vel, brk, err, deriv, mag, acc;
    motion_t r;
    if (op == ahpc_pkg::OP_HOME) begin
      m_phase = ahpc_pkg::PH_SEEK_LOW;
      return;
    end
    delta = longint'(ang) - longint'(m_prev_angle);
    if (delta > TURN / 2) delta -= TURN;
    else if (delta < -(TURN / 2)) delta += TURN;
    m_prev_angle = ang;
    m_pos_ticks = m_pos_ticks + delta[31:0];
    pos = longint'($signed(m_pos_ticks));
    span = longint'($signed(m_span));
    scaled = 0;
    if (span != 0) scaled = clamp(pos * SCALE / span, 0, SCALE);
    vel = 0;
    case (m_phase)
      ahpc_pkg::PH_SEEK_LOW: begin
        if (lo) begin m_phase = ahpc_pkg::PH_BACK_OFF; m_pos_ticks = 0; end
        else vel = -longint'(m_fast);
      end
      ahpc_pkg::PH_BACK_OFF: begin
        if (pos >= TURN) m_phase = ahpc_pkg::PH_SLOW_LOW;
        else vel = longint'(m_fast);
      end
      ahpc_pkg::PH_SLOW_LOW: begin
        if (lo) begin m_phase = ahpc_pkg::PH_SEEK_HIGH; m_pos_ticks = 0; end
        else vel = -longint'(m_slow);
      end
      ahpc_pkg::PH_SEEK_HIGH: begin
        if (hi) begin m_phase = ahpc_pkg::PH_BACK_HIGH; m_span = m_pos_ticks; end
        else vel = longint'(m_fast);
      end
      ahpc_pkg::PH_BACK_HIGH: begin
        if (pos <= span - TURN) m_phase = ahpc_pkg::PH_SLOW_HIGH;
        else vel = -longint'(m_fast);
      end
      ahpc_pkg::PH_SLOW_HIGH: begin
        if (hi) begin
          m_phase = ahpc_pkg::PH_CONTROL;
          m_cal = 1'b1;
          m_span = m_pos_ticks;
        end else vel = longint'(m_slow);
      end
      default: begin
        m_phase = ahpc_pkg::PH_CONTROL;
        err = (longint'(tgt) - scaled) / ahpc_pkg::ERROR_DIVISOR;
        mag = err < 0 ? -err : err;
        deriv = 0;
        if (dt != 0) deriv = (err - longint'(m_prev_err)) / longint'(dt);
        if (mag < longint'(m_dead)) m_integral = 0;
        else m_integral = 32'(clamp(longint'(m_integral) + err * longint'(dt),
                                    -64'sd2147483648, 64'sd2147483647));
        m_prev_err = 32'(err);
        acc = longint'(m_kp) * err + longint'(m_ki) * longint'(m_integral)
            - longint'(m_kd) * deriv;
        vel = clamp(acc / 256, -VMAX, VMAX);
      end
    endcase
    vel = clamp(vel, -VMAX, VMAX);
    if (lo && vel < 0) vel = 0;
    if (hi && vel > 0) vel = 0;
    brk = clamp(longint'(m_brake), 0, VMAX);
    r.drive = vel != 0;
    r.vel = 11'(vel);
    r.brake = vel != 0 ? 10'd0 : brk[9:0];
    r.scaled = scaled[9:0];
    r.phase = m_phase;
    r.cal = m_cal;
    pending_motion.push_back(r);
  endtask

  // sender: random gap, then hold the item until accepted
  task automatic send_item(input logic op, input logic lo, input logic hi,
                           input logic [18:0] ang, input logic [15:0] dt,
                           input logic [19:0] tgt);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_low_limit_hit <= lo;
    in_high_limit_hit <= hi;
    in_encoder_angle <= ang;
    in_elapsed_ms <= dt;
    in_target_position <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_item(op, lo, hi, ang, dt, tgt);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_motion.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_gains(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] dead,
                             input logic [15:0] fast, input logic [15:0] slow,
                             input logic [15:0] brk);
    logic [15:0] vals[7];
    vals = '{kp, ki, kd, dead, fast, slow, brk};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (ahpc_pkg::cfg_idx_t'(i))
        ahpc_pkg::CFG_KP:    m_kp = vals[i];
        ahpc_pkg::CFG_KI:    m_ki = vals[i];
        ahpc_pkg::CFG_KD:    m_kd = vals[i];
        ahpc_pkg::CFG_DEAD:  m_dead = vals[i][14:0];
        ahpc_pkg::CFG_FAST:  m_fast = vals[i][9:0];
        ahpc_pkg::CFG_SLOW:  m_slow = vals[i][9:0];
        ahpc_pkg::CFG_BRAKE: m_brake = vals[i][9:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic write_random_gains();
    write_gains(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024) - 512),
                16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64) - 32),
                16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 512) - 256),
                16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                16'($urandom_range(0, 1023)));
  endtask

  // picks moves and switch levels that walk the homing sequence forward
  task automatic guided_item();
    longint delta, a;
    logic lo, hi;
    logic [18:0] ang;
    logic [15:0] dt;
    logic [19:0] tgt;
    longint pos;
    pos = longint'($signed(m_pos_ticks));
    lo = $urandom_range(0, 11) == 0;
    hi = $urandom_range(0, 11) == 0;
    delta = longint'($urandom_range(0, 60000)) - 30000;
    case (m_phase)
      ahpc_pkg::PH_SEEK_LOW:  lo = $urandom_range(0, 3) == 0;
      ahpc_pkg::PH_BACK_OFF:  delta = $urandom_range(20000, 179000);
      ahpc_pkg::PH_SLOW_LOW:  lo = $urandom_range(0, 2) == 0;
      ahpc_pkg::PH_SEEK_HIGH: begin
        delta = $urandom_range(20000, 179000);
        hi = pos > 400000 ? $urandom_range(0, 2) == 0 : $urandom_range(0, 9) == 0;
      end
      ahpc_pkg::PH_BACK_HIGH: delta = -longint'($urandom_range(20000, 179000));
      ahpc_pkg::PH_SLOW_HIGH: hi = $urandom_range(0, 2) == 0;
      default: delta = longint'($urandom_range(0, 360000)) - 180000;
    endcase
    a = (longint'(m_prev_angle) + delta) % TURN;
    if (a < 0) a += TURN;
    ang = $urandom_range(0, 29) == 0 ? 19'($urandom) : 19'(a);
    dt = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 50));
    tgt = $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 1000000));
    if ($urandom_range(0, 99) < (m_phase == ahpc_pkg::PH_CONTROL ? 3 : 1))
      send_item(ahpc_pkg::OP_HOME, lo, hi, ang, dt, tgt);
    else
      send_item(ahpc_pkg::OP_TICK, lo, hi, ang, dt, tgt);
  endtask

  task automatic test_uncalibrated_defaults();
    send_item(ahpc_pkg::OP_TICK, 1'b0, 1'b0, 19'd0, 16'd0, 20'd0);
    send_item(ahpc_pkg::OP_TICK, 1'b1, 1'b1, 19'd359999, 16'd65535, 20'hFFFFF);
    settle();
  endtask

  task automatic test_field_extremes();
    write_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'd1023, 16'd1023, 16'd1023);
    send_item(ahpc_pkg::OP_TICK, 1'b0, 1'b0, 19'h7FFFF, 16'd0, 20'hFFFFF);
    send_item(ahpc_pkg::OP_TICK, 1'b0, 1'b1, 19'd0, 16'd65535, 20'd0);
    send_item(ahpc_pkg::OP_TICK, 1'b1, 1'b0, 19'd180000, 16'd1, 20'd1000000);
    send_item(ahpc_pkg::OP_TICK, 1'b0, 1'b0, 19'd359999, 16'd2, 20'd500);
    settle();
    write_gains(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    send_item(ahpc_pkg::OP_TICK, 1'b1, 1'b1, 19'd1, 16'd3, 20'hFFFFF);
    send_item(ahpc_pkg::OP_TICK, 1'b0, 1'b0, 19'd180001, 16'd0, 20'd0);
    settle();
    write_gains(16'h0100, 16'h0010, 16'h0020, 16'd5, 16'd1023, 16'd700, 16'hFFFF);
    // homing speed above the limit, limits against the homing direction
    send_item(ahpc_pkg::OP_HOME, 1'b1, 1'b1, 19'h7FFFF, 16'hFFFF, 20'hFFFFF);
    send_item(ahpc_pkg::OP_TICK, 1'b0, 1'b0, 19'd100, 16'd10, 20'd0);
    send_item(ahpc_pkg::OP_TICK, 1'b1, 1'b0, 19'd200, 16'd10, 20'd0);
    send_item(ahpc_pkg::OP_TICK, 1'b0, 1'b1, 19'd170000, 16'd10, 20'd0);
    // restart in the middle of homing
    send_item(ahpc_pkg::OP_HOME, 1'b0, 1'b0, 19'd0, 16'd0, 20'd0);
    send_item(ahpc_pkg::OP_TICK, 1'b0, 1'b0, 19'd340000, 16'd10, 20'd0);
    settle();
  endtask

  task automatic test_full_homing();
    write_gains(16'h0200, 16'h0004, 16'h0040, 16'd3, 16'd400, 16'd150, 16'd800);
    send_item(ahpc_pkg::OP_HOME, 1'b0, 1'b0, m_prev_angle, 16'd5, 20'd0);
    for (int i = 0; i < 300 && !(m_cal && m_phase == ahpc_pkg::PH_CONTROL); i++)
      guided_item();
    for (int i = 0; i < 40; i++) guided_item();
    settle();
  endtask

  task automatic test_guided_random(input int count);
    write_random_gains();
    for (int i = 0; i < count; i++) guided_item();
    settle();
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    motion_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_motion.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        e = pending_motion.pop_front();
        if (out_drive_active !== e.drive) begin
          $error("drive_active expected %0d got %0d", e.drive, out_drive_active);
          errors++;
        end
        if (out_velocity !== e.vel) begin
          $error("velocity expected %0d got %0d", e.vel, out_velocity);
          errors++;
        end
        if (out_brake_out !== e.brake) begin
          $error("brake_out expected %0d got %0d", e.brake, out_brake_out);
          errors++;
        end
        if (out_scaled_position !== e.scaled) begin
          $error("scaled_position expected %0d got %0d", e.scaled, out_scaled_position);
          errors++;
        end
        if (out_homing_phase_out !== e.phase) begin
          $error("homing_phase_out expected %0d got %0d", e.phase, out_homing_phase_out);
          errors++;
        end
        if (out_calibrated !== e.cal) begin
          $error("calibrated expected %0d got %0d", e.cal, out_calibrated);
          errors++;
        end
      end
    end
    out_ready <= $urandom_range(0, 99) >= stall_pct;
  end

  initial begin
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    m_kp = 0; m_ki = 0; m_kd = 0; m_dead = 0; m_fast = 0; m_slow = 0; m_brake = 0;
    m_phase = ahpc_pkg::PH_CONTROL; m_pos_ticks = 0; m_span = 0; m_prev_angle = 0;
    m_prev_err = 0; m_integral = 0; m_cal = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= ahpc_pkg::OP_TICK;
    in_low_limit_hit <= 1'b0;
    in_high_limit_hit <= 1'b0;
    in_encoder_angle <= '0;
    in_elapsed_ms <= '0;
    in_target_position <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_uncalibrated_defaults();
    test_field_extremes();
    test_full_homing();
    test_guided_random(220);
    send_idle_pct = 84;
    test_guided_random(220);
    send_idle_pct = 0;
    stall_pct = 84;
    test_guided_random(220);
    send_idle_pct = 35;
    stall_pct = 35;
    test_full_homing();
    test_guided_random(200);

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
